### hw/rtl/brs_pkg.sv
package brs_pkg;

    // Result event codes.
    localparam logic [1:0] EV_RECORD = 2'd1;
    localparam logic [1:0] EV_ERROR  = 2'd2;
    localparam logic [1:0] EV_END    = 2'd3;

    // Record format codes held in the configuration register.
    localparam logic [1:0] FMT_LENGTH = 2'd0;
    localparam logic [1:0] FMT_ATSIGN = 2'd1;
    localparam logic [1:0] FMT_KEYED  = 2'd2;

    // Characters the framer looks for.
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Result queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // One result item.
    typedef struct packed {
        logic [1:0]  ev;
        logic [31:0] off;
        logic [31:0] len;
        logic [29:0] key;
        logic        last;
    } t_result;

    // Results produced by one transfer into the framer, in delivery order.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // ASCII digits sit at 0x30..0x39, so the low nibble is the value.
    function automatic logic [3:0] digit_val(input logic [7:0] b);
        return b[3:0];
    endfunction

    function automatic logic [29:0] pow10(input int n);
        logic [29:0] p;
        p = 30'd1;
        for (int i = 0; i < n; i++) begin
            p = 30'(p * 30'd10);
        end
        return p;
    endfunction

    // Difference of two positions, clamped at zero.
    function automatic logic [31:0] span(input logic [31:0] from, input logic [31:0] to);
        return (to >= from) ? (to - from) : 32'd0;
    endfunction

    function automatic t_result mk_result(input logic [1:0] ev, input logic [31:0] off,
                                          input logic [31:0] len, input logic [29:0] key);
        t_result r;
        r.ev   = ev;
        r.off  = off;
        r.len  = len;
        r.key  = key;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

### hw/rtl/brs_framer.sv
module brs_framer #(
    parameter int KEY_DIGITS    = 9,
    parameter int LENGTH_DIGITS = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic [1:0]     i_cfg_wr_data,
    input  logic           i_fire,
    input  logic [7:0]     i_data_byte,
    input  logic           i_end_of_file,
    output brs_pkg::t_push o_push,
    output logic           o_stopped
);
    import brs_pkg::*;

    localparam int LW   = $clog2(10 ** LENGTH_DIGITS);
    localparam int MAXD = (KEY_DIGITS > LENGTH_DIGITS) ? KEY_DIGITS : LENGTH_DIGITS;
    localparam int HCW  = $clog2(MAXD + 1);
    localparam int HD   = KEY_DIGITS + 1;

    localparam logic PH_HEADER = 1'b0;
    localparam logic PH_BODY   = 1'b1;

    logic [1:0]     r_fmt;
    logic           r_phase, n_phase;
    logic [31:0]    r_pos, n_pos;
    logic [31:0]    r_begin, n_begin;
    logic [HCW-1:0] r_hc, n_hc;
    logic [LW-1:0]  r_lr, n_lr;
    logic [7:0]     r_hist [HD];
    logic [7:0]     n_hist [HD];
    logic [29:0]    r_cur_key, n_cur_key;
    logic [29:0]    r_cand_key, n_cand_key;
    logic           r_stopped, n_stopped;

    logic [31:0]    pos_nxt;
    logic [31:0]    span_pos;
    logic [31:0]    key_start;
    logic [HCW-1:0] hc_inc;
    logic [LW-1:0]  lr_base;
    logic [LW+2:0]  lr_wide;
    logic [LW-1:0]  lr_acc;
    logic [29:0]    cand_base;
    logic [32:0]    cand_wide;
    logic [29:0]    cand_acc;
    logic [3:0]     dig;
    logic [29:0]    line_key;
    logic           line_key_ok;
    logic           line_mark;
    logic           err;
    logic           p1_v, p2_v;
    t_result        p1, p2, pe;

    // Position arithmetic shared by all formats; the position saturates.
    assign pos_nxt   = (r_pos == 32'hFFFF_FFFF) ? r_pos : r_pos + 32'd1;
    assign span_pos  = span(r_begin, r_pos);
    assign key_start = (span_pos > 32'(KEY_DIGITS)) ? r_pos - 32'(KEY_DIGITS) : r_begin;
    assign hc_inc    = r_hc + 1'b1;
    assign dig       = digit_val(i_data_byte);

    // Decimal accumulators, times ten as two shifts and an add.
    assign lr_base   = (r_hc == '0) ? '0 : r_lr;
    assign lr_wide   = {lr_base, 3'b000} + {2'b00, lr_base, 1'b0} + {{(LW - 1){1'b0}}, dig};
    assign lr_acc    = lr_wide[LW-1:0];
    assign cand_base = (r_hc == '0) ? 30'd0 : r_cand_key;
    assign cand_wide = {cand_base, 3'b000} + {2'b00, cand_base, 1'b0} + {29'd0, dig};
    assign cand_acc  = cand_wide[29:0];

    // Key of a line held in the history, as a weighted sum of its digits.
    always_comb begin
        line_key    = 30'd0;
        line_key_ok = 1'b1;
        for (int k = 0; k < KEY_DIGITS; k++) begin
            line_key    = line_key + 30'(30'(digit_val(r_hist[k])) * pow10(k));
            line_key_ok = line_key_ok & is_digit(r_hist[k]);
        end
    end

    assign line_mark = (i_data_byte == CH_SPACE) && (r_hist[KEY_DIGITS] == CH_LF);

    // Next state and the results of one transfer.
    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_begin    = r_begin;
        n_hc       = r_hc;
        n_lr       = r_lr;
        n_hist     = r_hist;
        n_cur_key  = r_cur_key;
        n_cand_key = r_cand_key;
        n_stopped  = r_stopped;
        err        = 1'b0;
        p1_v       = 1'b0;
        p2_v       = 1'b0;
        p1         = mk_result(EV_RECORD, r_begin, 32'd0, 30'd0);
        p2         = mk_result(EV_END, r_pos, 32'd0, 30'd0);
        pe         = mk_result(EV_ERROR, r_pos, 32'd0, 30'd0);

        if (i_fire && !r_stopped) begin
            priority if (r_fmt > FMT_KEYED) begin
                err = 1'b1;
            end else if (i_end_of_file) begin
                // End of stream: close an open text body and report the end; mid-header or in a length body, an error.
                n_stopped = 1'b1;
                priority if (r_phase == PH_HEADER) begin
                    if (r_hc == '0) begin
                        p2_v = 1'b1;
                    end else begin
                        err = 1'b1;
                    end
                end else if (r_fmt == FMT_LENGTH) begin
                    err = 1'b1;
                end else begin
                    p1_v = (span_pos != 32'd0) || (r_fmt == FMT_KEYED);
                    p1   = mk_result(EV_RECORD, r_begin, span_pos,
                                     (r_fmt == FMT_KEYED) ? r_cur_key : 30'd0);
                    p2_v = 1'b1;
                end
            end else begin
                unique case (r_fmt)
                    FMT_LENGTH: begin
                        if (r_phase == PH_HEADER) begin
                            // Length field, one digit per byte.
                            if (r_hc == '0) begin
                                n_begin = r_pos;
                            end
                            if (!is_digit(i_data_byte)) begin
                                err = 1'b1;
                            end else begin
                                n_lr = lr_acc;
                                n_hc = hc_inc;
                                if (hc_inc >= HCW'(LENGTH_DIGITS)) begin
                                    if (lr_acc <= LW'(LENGTH_DIGITS)) begin
                                        err = 1'b1;
                                    end else begin
                                        n_lr    = lr_acc - LW'(LENGTH_DIGITS);
                                        n_hc    = '0;
                                        n_phase = PH_BODY;
                                    end
                                end
                            end
                        end else begin
                            // Body countdown; the record closes on its last byte.
                            n_lr = (r_lr != '0) ? r_lr - 1'b1 : r_lr;
                            if (r_lr <= LW'(1)) begin
                                p1_v    = 1'b1;
                                p1      = mk_result(EV_RECORD, r_begin,
                                                    span(r_begin, pos_nxt), 30'd0);
                                n_phase = PH_HEADER;
                                n_hc    = '0;
                            end
                        end
                    end
                    FMT_ATSIGN: begin
                        if (r_phase == PH_HEADER) begin
                            // Header is an at-sign, an optional CR, then LF.
                            priority if (r_hc == '0) begin
                                if (i_data_byte == CH_AT) begin
                                    n_hc = HCW'(1);
                                end else begin
                                    err = 1'b1;
                                end
                            end else if ((r_hc == HCW'(1)) && (i_data_byte == CH_CR)) begin
                                n_hc = HCW'(2);
                            end else if (i_data_byte == CH_LF) begin
                                n_hc    = '0;
                                n_phase = PH_BODY;
                                n_begin = pos_nxt;
                            end else begin
                                err = 1'b1;
                            end
                        end else if ((i_data_byte == CH_AT) && (r_hist[0] == CH_LF)) begin
                            // An at-sign at a line start opens the next header; after an empty body it ends the scan.
                            p1_v = 1'b1;
                            if (span_pos == 32'd0) begin
                                p1        = mk_result(EV_END, r_pos, 32'd0, 30'd0);
                                n_stopped = 1'b1;
                            end else begin
                                p1      = mk_result(EV_RECORD, r_begin, span_pos, 30'd0);
                                n_phase = PH_HEADER;
                                n_hc    = HCW'(1);
                            end
                        end
                    end
                    default: begin
                        if (r_phase == PH_HEADER) begin
                            // Key digits, then one space.
                            if (r_hc == '0) begin
                                n_begin    = r_pos;
                                n_cand_key = 30'd0;
                            end
                            priority if (r_hc < HCW'(KEY_DIGITS)) begin
                                if (!is_digit(i_data_byte)) begin
                                    err = 1'b1;
                                end else begin
                                    n_cand_key = cand_acc;
                                    n_hc       = hc_inc;
                                end
                            end else if (i_data_byte == CH_SPACE) begin
                                n_cur_key = r_cand_key;
                                n_hc      = '0;
                                n_phase   = PH_BODY;
                            end else begin
                                err = 1'b1;
                            end
                        end else if (line_mark) begin
                            // A line key that differs from the current one splits here; a non-digit key is an error.
                            if (!line_key_ok) begin
                                err = 1'b1;
                            end else if (line_key != r_cur_key) begin
                                p1_v      = 1'b1;
                                p1        = mk_result(EV_RECORD, r_begin,
                                                      span(r_begin, key_start), r_cur_key);
                                n_begin   = key_start;
                                n_cur_key = line_key;
                            end
                        end
                    end
                endcase
            end

            if (err) begin
                n_stopped = 1'b1;
            end

            // History and position advance only on a real byte.
            if (!i_end_of_file) begin
                for (int k = HD - 1; k > 0; k--) begin
                    n_hist[k] = r_hist[k-1];
                end
                n_hist[0] = i_data_byte;
                n_pos     = pos_nxt;
            end
        end
    end

    // Order the results; an error never shares a transfer with another result.
    always_comb begin
        o_push.r0 = p1_v ? p1 : (p2_v ? p2 : pe);
        o_push.r1 = p2;
        o_push.r0.last = !(p1_v && p2_v);
        o_push.r1.last = 1'b1;
        priority if (i_cfg_wr_en) begin
            o_push.cnt = 2'd0;
        end else if (p1_v && p2_v) begin
            o_push.cnt = 2'd2;
        end else if (p1_v || p2_v || err) begin
            o_push.cnt = 2'd1;
        end else begin
            o_push.cnt = 2'd0;
        end
    end

    assign o_stopped = r_stopped;

    // A register write restarts the scan just as reset does.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en) begin
            r_fmt      <= i_rst_n ? i_cfg_wr_data : FMT_LENGTH;
            r_phase    <= PH_HEADER;
            r_pos      <= 32'd0;
            r_begin    <= 32'd0;
            r_hc       <= '0;
            r_lr       <= '0;
            r_cur_key  <= 30'd0;
            r_cand_key <= 30'd0;
            r_stopped  <= 1'b0;
            for (int k = 0; k < HD; k++) begin
                r_hist[k] <= 8'd0;
            end
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_begin    <= n_begin;
            r_hc       <= n_hc;
            r_lr       <= n_lr;
            r_hist     <= n_hist;
            r_cur_key  <= n_cur_key;
            r_cand_key <= n_cand_key;
            r_stopped  <= n_stopped;
        end
    end

endmodule

### hw/rtl/brs_out_queue.sv
module brs_out_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  brs_pkg::t_push        i_push,
    input  logic                  i_ready,
    output logic                  o_valid,
    output brs_pkg::t_result      o_head,
    output logic [brs_pkg::QCW-1:0] o_count
);
    import brs_pkg::*;

    t_result          r_mem [QDEPTH];
    logic [QPW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0]   r_count, n_count;
    logic [QPW-1:0]   wr_ptr_2nd;
    logic             pop;

    assign o_valid    = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];
    assign o_count    = r_count;
    assign pop        = o_valid && i_ready;
    assign wr_ptr_2nd = r_wr_ptr + 1'b1;

    // Pointer and fill bookkeeping: up to two pushes and one pop per cycle.
    always_comb begin
        n_wr_ptr = r_wr_ptr + QPW'(i_push.cnt);
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + QCW'(i_push.cnt) - QCW'(pop);
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr_2nd] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### hw/rtl/bibliographic_record_splitter.sv
// Record framer for bibliographic byte streams. One file byte (or the end-of-file
// mark) is taken per transfer and the block reports each record it finds as a
// result of offset, length and key, in the length-prefixed, at-sign delimited or
// keyed-line format chosen by the format register; writing that register restarts
// the scan. The whole framing decision for a transfer is made in one pass of logic
// from the scan registers, and its zero, one or two results go into a four-entry
// result queue that delivers one result per cycle when taken. The input is ready
// whenever the queue has room for two results, so the block keeps one byte per
// cycle as long as results are taken at that rate. An error or the clean end of
// the stream stops the scan until the register is written or the block is reset.
module bibliographic_record_splitter #(
    parameter int KEY_DIGITS    = 9,
    parameter int LENGTH_DIGITS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_file,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_event_res,
    output logic [31:0] o_record_offset,
    output logic [31:0] o_record_length,
    output logic [29:0] o_record_key,
    output logic        o_last_result
);
    import brs_pkg::*;

    t_push          push;
    t_result        head;
    logic [QCW-1:0] q_count;
    logic           stopped;
    logic           fire;

    // An input transfer needs room for the largest burst of results.
    assign o_ready = (q_count <= QCW'(QDEPTH - 2));
    assign fire    = i_valid && o_ready;

    brs_framer #(
        .KEY_DIGITS    (KEY_DIGITS),
        .LENGTH_DIGITS (LENGTH_DIGITS)
    ) u_framer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (fire),
        .i_data_byte   (i_data_byte),
        .i_end_of_file (i_end_of_file),
        .o_push        (push),
        .o_stopped     (stopped)
    );

    brs_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_head  (head),
        .o_count (q_count)
    );

    assign o_event_res     = head.ev;
    assign o_record_offset = head.off;
    assign o_record_length = head.len;
    assign o_record_key    = head.key;
    assign o_last_result   = head.last;

    // A stopped scan produces nothing.
    a_stopped_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && stopped && !i_cfg_wr_en) |-> (push.cnt == 2'd0))
        else $error("stopped framer produced a result");

    // An error result always stops the scan.
    a_error_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.cnt != 2'd0 && push.r0.ev == EV_ERROR && !i_cfg_wr_en) |=> stopped)
        else $error("error result without stop");

    // The queue never overfills.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= QCW'(QDEPTH))
        else $error("result queue overflow");

    // A result that is not the last of its transfer has its partner queued behind it.
    a_pair_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_result) |-> (q_count >= QCW'(2)))
        else $error("first of a result pair delivered alone");

endmodule

### dv/bibliographic_record_splitter_tb.sv
module bibliographic_record_splitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brs_pkg::*;

    localparam int KEY_DIGITS    = 9;
    localparam int LENGTH_DIGITS = 5;

    // The register field is two bits wide, so the code past the keyed format can be written.
    localparam logic [1:0] FMT_UNKNOWN = 2'd3;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int MAX_KEY       = 999999999;

    // Keeps its own copy of the framer state and the records it expects to see.
    class framer_scoreboard;
        logic [1:0]  fmt;
        bit          in_body;
        bit          halted;
        logic [31:0] pos;
        logic [31:0] rec_start;
        int unsigned hdr_cnt;
        logic [31:0] len_left;
        logic [7:0]  hist [10];
        logic [29:0] key_now;
        logic [29:0] key_cand;
        t_result     expected_records [$];
        t_result     fresh [$];
        int          errors;
        int          checked;

        function new();
            errors  = 0;
            checked = 0;
            restart(FMT_LENGTH);
        endfunction

        // A register write starts the scan over, just as a reset does.
        function void restart(logic [1:0] f);
            fmt       = f;
            in_body   = 1'b0;
            halted    = 1'b0;
            pos       = '0;
            rec_start = '0;
            hdr_cnt   = 0;
            len_left  = '0;
            key_now   = '0;
            key_cand  = '0;
            foreach (hist[i]) hist[i] = 8'h00;
        endfunction

        function int pending();
            return expected_records.size();
        endfunction

        function bit is_dec(logic [7:0] c);
            return (c >= CH_ZERO) && (c <= CH_NINE);
        endfunction

        function logic [31:0] pos_gap(logic [31:0] from, logic [31:0] to);
            return (to >= from) ? to - from : 32'd0;
        endfunction

        function void stage(logic [1:0] ev, logic [31:0] off, logic [31:0] len,
                            logic [29:0] key);
            t_result r;
            r.ev   = ev;
            r.off  = off;
            r.len  = len;
            r.key  = key;
            r.last = 1'b0;
            fresh  = {fresh, r};
        endfunction

        // Works out the results that one accepted input transfer causes.
        function void take_byte(logic [7:0] b, logic eof);
            logic [31:0] nxt;
            logic [31:0] blen;
            logic [31:0] line_key;
            logic [31:0] start;
            t_result     r;
            bit          err;
            fresh.delete();
            err = 1'b0;
            if (halted) return;
            nxt = (pos == 32'hFFFF_FFFF) ? pos : pos + 32'd1;

            if (fmt > FMT_KEYED) begin
                err = 1'b1;
            end else if (eof) begin
                // End of stream: clean at a boundary, an error inside a header or a
                // length-prefixed record, and a final record in a text body.
                if (!in_body) begin
                    if (hdr_cnt == 0) stage(EV_END, pos, '0, '0);
                    else err = 1'b1;
                end else if (fmt == FMT_LENGTH) begin
                    err = 1'b1;
                end else begin
                    blen = pos_gap(rec_start, pos);
                    if (blen != 0 || fmt == FMT_KEYED) begin
                        stage(EV_RECORD, rec_start, blen, (fmt == FMT_KEYED) ? key_now : 30'd0);
                    end
                    stage(EV_END, pos, '0, '0);
                end
                halted = 1'b1;
            end else if (fmt == FMT_LENGTH) begin
                if (!in_body) begin
                    if (hdr_cnt == 0) begin
                        rec_start = pos;
                        len_left  = '0;
                    end
                    if (!is_dec(b)) begin
                        err = 1'b1;
                    end else begin
                        len_left = len_left * 10 + (b - CH_ZERO);
                        hdr_cnt++;
                        if (hdr_cnt >= LENGTH_DIGITS) begin
                            if (len_left <= LENGTH_DIGITS) begin
                                err = 1'b1;
                            end else begin
                                len_left = len_left - LENGTH_DIGITS;
                                hdr_cnt  = 0;
                                in_body  = 1'b1;
                            end
                        end
                    end
                end else begin
                    if (len_left > 0) len_left--;
                    if (len_left == 0) begin
                        stage(EV_RECORD, rec_start, pos_gap(rec_start, nxt), '0);
                        in_body = 1'b0;
                        hdr_cnt = 0;
                    end
                end
            end else if (fmt == FMT_ATSIGN) begin
                if (!in_body) begin
                    if (hdr_cnt == 0) begin
                        if (b == CH_AT) hdr_cnt = 1;
                        else err = 1'b1;
                    end else if (hdr_cnt == 1 && b == CH_CR) begin
                        hdr_cnt = 2;
                    end else if (b == CH_LF) begin
                        hdr_cnt   = 0;
                        in_body   = 1'b1;
                        rec_start = nxt;
                    end else begin
                        err = 1'b1;
                    end
                end else if (b == CH_AT && hist[0] == CH_LF) begin
                    // An at-sign at a line start closes the body; an empty one ends the scan.
                    blen = pos_gap(rec_start, pos);
                    if (blen == 0) begin
                        stage(EV_END, pos, '0, '0);
                        halted = 1'b1;
                    end else begin
                        stage(EV_RECORD, rec_start, blen, '0);
                        in_body = 1'b0;
                        hdr_cnt = 1;
                    end
                end
            end else begin
                if (!in_body) begin
                    if (hdr_cnt == 0) begin
                        rec_start = pos;
                        key_cand  = '0;
                    end
                    if (hdr_cnt < KEY_DIGITS) begin
                        if (!is_dec(b)) begin
                            err = 1'b1;
                        end else begin
                            key_cand = 30'(key_cand * 10 + (b - CH_ZERO));
                            hdr_cnt++;
                        end
                    end else if (b == CH_SPACE) begin
                        key_now = key_cand;
                        hdr_cnt = 0;
                        in_body = 1'b1;
                    end else begin
                        err = 1'b1;
                    end
                end else if (b == CH_SPACE && hist[KEY_DIGITS] == CH_LF) begin
                    // The digits between the line end and this space are a line key.
                    line_key = '0;
                    for (int k = KEY_DIGITS; k > 0 && !err; k--) begin
                        if (!is_dec(hist[k-1])) err = 1'b1;
                        else line_key = line_key * 10 + (hist[k-1] - CH_ZERO);
                    end
                    if (!err && line_key[29:0] != key_now) begin
                        if (pos_gap(rec_start, pos) > KEY_DIGITS) start = pos - KEY_DIGITS;
                        else start = rec_start;
                        stage(EV_RECORD, rec_start, pos_gap(rec_start, start), key_now);
                        rec_start = start;
                        key_now   = line_key[29:0];
                    end
                end
            end

            if (err) begin
                stage(EV_ERROR, pos, '0, '0);
                halted = 1'b1;
            end
            if (!eof) begin
                for (int i = 9; i > 0; i--) hist[i] = hist[i-1];
                hist[0] = b;
                pos     = nxt;
            end
            foreach (fresh[i]) begin
                r                = fresh[i];
                r.last           = (i == fresh.size() - 1);
                expected_records = {expected_records, r};
            end
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task compare(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) begin
                report($sformatf("result %0d %s: got %0h, expected %0h",
                                 checked, name, got, want));
            end
        endtask

        // Checks one result transfer against the oldest expected record.
        task check_result(logic [1:0] ev, logic [31:0] off, logic [31:0] len,
                          logic [29:0] key, logic last);
            t_result want;
            checked++;
            if (expected_records.size() == 0) begin
                report($sformatf("result %0d arrived with nothing pending (ev %0d, offset %0d)",
                                 checked, ev, off));
                return;
            end
            want = expected_records.pop_front();
            compare("event", 32'(ev), 32'(want.ev));
            compare("offset", off, want.off);
            compare("length", len, want.len);
            compare("key", 32'(key), 32'(want.key));
            compare("last", 32'(last), 32'(want.last));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_wr_en    = 1'b0;
    logic [1:0]  i_cfg_wr_data  = FMT_LENGTH;
    logic        i_valid        = 1'b0;
    logic [7:0]  i_data_byte    = 8'h00;
    logic        i_end_of_file  = 1'b0;
    logic        i_ready        = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_event_res;
    logic [31:0] o_record_offset;
    logic [31:0] o_record_length;
    logic [29:0] o_record_key;
    logic        o_last_result;

    framer_scoreboard sb;
    logic [7:0]       file_q [$];
    int               items_sent     = 0;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    bit               hold_req       = 1'b0;
    int               quiet_cycles   = 0;

    bibliographic_record_splitter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_file   (i_end_of_file),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_event_res     (o_event_res),
        .o_record_offset (o_record_offset),
        .o_record_length (o_record_length),
        .o_record_key    (o_record_key),
        .o_last_result   (o_last_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Result side: random stalls, plus one long hold-off when requested.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Every result transfer is checked in order.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_event_res, o_record_offset, o_record_length, o_record_key,
                            o_last_result);
        end
    end

    // Ends the run if no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_wr_en) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("bibliographic_record_splitter_tb: done, errors");
            $finish;
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
        endcase
    endtask

    // Offers one byte or end-of-file mark and holds it until the input transfer.
    task automatic send_item(input logic [7:0] b, input logic eof);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_valid       <= 1'b1;
        i_data_byte   <= b;
        i_end_of_file <= eof;
        do @(posedge i_clk); while (!o_ready);
        sb.take_byte(b, eof);
        items_sent++;
    endtask

    task automatic send_file(input bit with_eof);
        foreach (file_q[i]) send_item(file_q[i], 1'b0);
        if (with_eof) send_item(8'($urandom_range(0, 255)), 1'b1);
        file_q.delete();
    endtask

    task automatic drain_results();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The format register is only written once the block has gone quiet.
    task automatic load_format(input logic [1:0] f);
        i_valid <= 1'b0;
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= f;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.restart(f);
    endtask

    // Appends one byte to the file being built.
    task automatic add_byte(input logic [7:0] c);
        file_q = {file_q, c};
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic put_number(input int unsigned v, input int digits);
        logic [7:0] d [$];
        repeat (digits) begin
            d.push_front(CH_ZERO + 8'(v % 10));
            v = v / 10;
        end
        foreach (d[i]) add_byte(d[i]);
    endtask

    // Text bytes that cannot start a new line key or at-sign header by accident.
    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_LF || c == CH_AT);
        return c;
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c >= CH_ZERO && c <= CH_NINE);
        return c;
    endfunction

    function automatic int unsigned pick_key();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return MAX_KEY;
            default: return $urandom_range(0, MAX_KEY);
        endcase
    endfunction

    task automatic build_length_file();
        int count;
        int rec_len;
        count = $urandom_range(1, 6);
        for (int r = 0; r < count; r++) begin
            rec_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160)
                                                  : $urandom_range(6, 30);
            put_number(rec_len, LENGTH_DIGITS);
            repeat (rec_len - LENGTH_DIGITS) add_byte(8'($urandom_range(0, 255)));
        end
        // Now and then a closing length that is too small.
        if ($urandom_range(0, 5) == 0) put_number($urandom_range(0, LENGTH_DIGITS), LENGTH_DIGITS);
    endtask

    task automatic build_atsign_file();
        int count;
        count = $urandom_range(1, 6);
        for (int r = 0; r < count; r++) begin
            add_byte(CH_AT);
            if ($urandom_range(0, 2) == 0) add_byte(CH_CR);
            add_byte(CH_LF);
            repeat ($urandom_range(0, 20)) add_byte(plain_byte());
            add_byte(CH_LF);
        end
        case ($urandom_range(0, 5))
            0: put_text("@\n@");
            1: put_text("@\r\n");
            default: ;
        endcase
    endtask

    task automatic build_keyed_file();
        int          count;
        int          idx;
        int unsigned key;
        count = $urandom_range(1, 8);
        key   = pick_key();
        for (int l = 0; l < count; l++) begin
            if (l > 0 && $urandom_range(0, 1) == 0) key = pick_key();
            put_number(key, KEY_DIGITS);
            add_byte(CH_SPACE);
            repeat ($urandom_range(0, 12)) add_byte(plain_byte());
            add_byte(CH_LF);
        end
        // Sometimes a line key with a non-digit in it.
        if ($urandom_range(0, 4) == 0) begin
            put_number(pick_key(), KEY_DIGITS);
            idx = file_q.size() - 1 - $urandom_range(0, KEY_DIGITS - 1);
            file_q[idx] = non_digit();
            add_byte(CH_SPACE);
        end
    endtask

    // One file: mostly well formed, sometimes noise, a corrupted byte or a cut.
    task automatic run_random_file(input logic [1:0] f);
        int roll;
        int cut;
        load_format(f);
        roll = $urandom_range(0, 99);
        if (roll < 8 || f == FMT_UNKNOWN) begin
            repeat ($urandom_range(5, 40)) add_byte(8'($urandom_range(0, 255)));
        end else begin
            case (f)
                FMT_LENGTH: build_length_file();
                FMT_ATSIGN: build_atsign_file();
                default:    build_keyed_file();
            endcase
        end
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (roll < 22) begin
            cut = $urandom_range(0, file_q.size() - 1);
            while (file_q.size() > cut) void'(file_q.pop_back());
        end
        send_file($urandom_range(0, 9) != 0);
    endtask

    initial begin
        int         file_no;
        int         start_items;
        logic [1:0] f;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cases: the unknown format code, several kinds of format error,
        // the empty at-sign body, end of stream in several places and input after a stop.
        load_format(FMT_UNKNOWN);
        send_item(CH_NINE, 1'b0);

        load_format(FMT_LENGTH);
        put_text("00006");
        add_byte(8'hFF);
        send_file(1'b1);
        send_item(CH_ZERO, 1'b0);

        load_format(FMT_LENGTH);
        put_text("99999");
        send_file(1'b1);

        load_format(FMT_LENGTH);
        put_text("00005");
        send_file(1'b0);

        load_format(FMT_LENGTH);
        put_text("0/");
        send_file(1'b0);

        load_format(FMT_LENGTH);
        put_text("1:");
        send_file(1'b0);

        load_format(FMT_LENGTH);
        put_text("12");
        send_file(1'b1);

        load_format(FMT_ATSIGN);
        put_text("@\n@");
        send_file(1'b0);

        load_format(FMT_ATSIGN);
        put_text("@\rx");
        send_file(1'b0);

        load_format(FMT_KEYED);
        put_text("12a");
        send_file(1'b0);

        load_format(FMT_KEYED);
        put_text("000000000x");
        send_file(1'b0);

        // Back-pressure: short records while the result side holds off, so the
        // queue fills and the input side has to stall.
        load_format(FMT_LENGTH);
        set_idling(0);
        repeat (30) begin
            put_number(LENGTH_DIGITS + 1, LENGTH_DIGITS);
            add_byte(8'($urandom_range(0, 255)));
        end
        hold_req = 1'b1;
        send_file(1'b1);

        // Random files, rotating through the idling patterns every few files.
        file_no     = 0;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            set_idling((file_no / 3) % 4);
            f = ($urandom_range(0, 29) == 0) ? FMT_UNKNOWN : 2'($urandom_range(0, 2));
            run_random_file(f);
            file_no++;
        end

        i_valid <= 1'b0;
        drain_results();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("bibliographic_record_splitter_tb: done, clean");
        end else begin
            $display("bibliographic_record_splitter_tb: done, errors");
        end
        $finish;
    end

endmodule
